@@ design/wsd_pkg.sv @@
// shared types, constants and opcode decode for the websocket frame deframer
package wsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned LenW   = 64;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned CntW   = 3;
  localparam int unsigned PosW   = 2;
  localparam int unsigned OpW    = 4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [CntW-1:0] LAST_LEN16_BYTE = 3'd1;
  localparam logic [CntW-1:0] LAST_LEN64_BYTE = 3'd7;
  localparam logic [CntW-1:0] LAST_KEY_BYTE   = 3'd3;

  localparam logic [OpW-1:0] OP_CONT   = 4'h0;
  localparam logic [OpW-1:0] OP_TEXT   = 4'h1;
  localparam logic [OpW-1:0] OP_BINARY = 4'h2;
  localparam logic [OpW-1:0] OP_CLOSE  = 4'h8;
  localparam logic [OpW-1:0] OP_PING   = 4'h9;
  localparam logic [OpW-1:0] OP_PONG   = 4'hA;

  localparam logic [KindW-1:0] KIND_CONT     = 3'd0;
  localparam logic [KindW-1:0] KIND_TEXT     = 3'd1;
  localparam logic [KindW-1:0] KIND_BINARY   = 3'd2;
  localparam logic [KindW-1:0] KIND_CLOSE    = 3'd3;
  localparam logic [KindW-1:0] KIND_PING     = 3'd4;
  localparam logic [KindW-1:0] KIND_PONG     = 3'd5;
  localparam logic [KindW-1:0] KIND_RESERVED = 3'd6;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [KindW-1:0] frame_kind;
    logic             final_fragment;
    logic             was_masked;
    logic             last_of_frame;
    logic             empty_frame;
  } result_t;

  function automatic logic [KindW-1:0] kind_of(input logic [OpW-1:0] op);
    logic [KindW-1:0] k;
    case (op)
      OP_CONT:   k = KIND_CONT;
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_CLOSE:  k = KIND_CLOSE;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      default:   k = KIND_RESERVED;
    endcase
    return k;
  endfunction

endpackage

@@ design/websocket_frame_deframer.sv @@
// top level of the websocket frame deframer
//
// Takes a raw websocket frame stream one byte per transfer on the in_ channel
// and gives one result per payload byte on the out_ channel: the unmasked
// byte with the frame kind, fin and mask flags and a last-of-frame mark.
// A frame with no payload gives one result marked empty on the byte that
// completes its header. Header, extended length and key bytes give none.
// Both channels use valid and stall; a transfer happens on a rising edge
// with valid high and stall low.
// A byte taken into the input register moves through the parser step into the
// result register. Throughput: one byte per cycle while the output is not
// stalled, set by the combinational parser step between the two registers.
// While the result register holds a stalled result, the input register still
// takes one more byte; in_stall rises only when both are full.
// Synchronous reset (rst_n low) empties both registers and returns the parser
// to waiting for the first header byte.
module websocket_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wsd_pkg::ByteW-1:0]      in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wsd_pkg::ByteW-1:0]      out_data_byte,
  output logic [wsd_pkg::KindW-1:0]      out_frame_kind,
  output logic                           out_final_fragment,
  output logic                           out_was_masked,
  output logic                           out_last_of_frame,
  output logic                           out_empty_frame
);

  logic                      byte_valid;
  logic [wsd_pkg::ByteW-1:0] byte_data;
  logic                      slot_free;
  logic                      advance;
  logic                      res_valid;
  wsd_pkg::result_t          res;
  wsd_pkg::result_t          out_res;

  assign advance = byte_valid & slot_free;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .advance    (advance),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .b         (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .slot_free (slot_free)
  );

  assign out_data_byte      = out_res.data_byte;
  assign out_frame_kind     = out_res.frame_kind;
  assign out_final_fragment = out_res.final_fragment;
  assign out_was_masked     = out_res.was_masked;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_empty_frame    = out_res.empty_frame;

  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register free");

  // parser never produces a result without a free result slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> slot_free)
    else $error("result produced into a full result register");

  // empty frame result is the last of its frame with void data
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_frame) |-> (out_last_of_frame && out_data_byte == '0))
    else $error("malformed empty frame result");

  // a result the parser produces shows as valid output in the next cycle
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid)
    else $error("result lost on its way to the output");

endmodule

@@ design/wsd_in_reg.sv @@
// input register holding one raw stream byte ahead of the parser
module wsd_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [wsd_pkg::ByteW-1:0]     in_byte,
  input  logic                          advance,
  output logic                          in_stall,
  output logic                          byte_valid,
  output logic [wsd_pkg::ByteW-1:0]     byte_data
);

  logic                      valid_r, valid_nxt;
  logic [wsd_pkg::ByteW-1:0] byte_r;

  // full register may only refill when its byte moves on
  assign in_stall = valid_r & ~advance;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

@@ design/wsd_parser.sv @@
// frame header parser, length and key capture, payload unmasking
module wsd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [wsd_pkg::ByteW-1:0] b,
  output logic                      res_valid,
  output wsd_pkg::result_t          res
);

  wsd_pkg::phase_t            phase_r, phase_nxt;
  logic [wsd_pkg::OpW-1:0]    op_r, op_nxt;
  logic                       fin_r, fin_nxt;
  logic                       mask_r, mask_nxt;
  logic [wsd_pkg::LenW-1:0]   left_r, left_nxt;
  logic [wsd_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic [wsd_pkg::KeyW-1:0]   key_r, key_nxt;
  logic [wsd_pkg::PosW-1:0]   pos_r, pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_HDR0;
      op_r    <= '0;
      fin_r   <= 1'b0;
      mask_r  <= 1'b0;
      left_r  <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    logic                     len_done;
    logic                     pay_start;
    logic [wsd_pkg::LenW-1:0] shifted;
    logic [wsd_pkg::ByteW-1:0] kbyte;
    logic                     last;

    phase_nxt = phase_r;
    op_nxt    = op_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    pos_nxt   = pos_r;
    res_valid = 1'b0;
    len_done  = 1'b0;
    pay_start = 1'b0;
    last      = 1'b0;
    shifted   = {left_r[wsd_pkg::LenW-wsd_pkg::ByteW-1:0], b};
    kbyte     = '0;
    res.data_byte      = '0;
    res.frame_kind     = wsd_pkg::kind_of(op_r);
    res.final_fragment = fin_r;
    res.was_masked     = mask_r;
    res.last_of_frame  = 1'b0;
    res.empty_frame    = 1'b0;

    if (step) begin
      case (phase_r)
        wsd_pkg::PH_HDR1: begin
          mask_nxt = b[7];
          cnt_nxt  = '0;
          left_nxt = '0;
          if (b[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_nxt = wsd_pkg::PH_LEN16;
          end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_nxt = wsd_pkg::PH_LEN64;
          end else begin
            left_nxt = {{(wsd_pkg::LenW-7){1'b0}}, b[6:0]};
            len_done = 1'b1;
          end
        end
        wsd_pkg::PH_LEN16: begin
          left_nxt = shifted;
          if (cnt_r >= wsd_pkg::LAST_LEN16_BYTE) begin
            len_done = 1'b1;
          end else begin
            cnt_nxt = cnt_r + wsd_pkg::CntW'(1);
          end
        end
        wsd_pkg::PH_LEN64: begin
          left_nxt = shifted;
          if (cnt_r >= wsd_pkg::LAST_LEN64_BYTE) begin
            len_done = 1'b1;
          end else begin
            cnt_nxt = cnt_r + wsd_pkg::CntW'(1);
          end
        end
        wsd_pkg::PH_KEY: begin
          key_nxt = {key_r[wsd_pkg::KeyW-wsd_pkg::ByteW-1:0], b};
          if (cnt_r >= wsd_pkg::LAST_KEY_BYTE) begin
            cnt_nxt   = '0;
            pay_start = 1'b1;
          end else begin
            cnt_nxt = cnt_r + wsd_pkg::CntW'(1);
          end
        end
        wsd_pkg::PH_DATA: begin
          if (mask_r) begin
            case (pos_r)
              2'd0:    kbyte = key_r[31:24];
              2'd1:    kbyte = key_r[23:16];
              2'd2:    kbyte = key_r[15:8];
              default: kbyte = key_r[7:0];
            endcase
          end
          pos_nxt = pos_r + wsd_pkg::PosW'(1);
          if (left_r != '0) begin
            left_nxt = left_r - wsd_pkg::LenW'(1);
          end
          last = (left_r[wsd_pkg::LenW-1:1] == '0);
          if (last) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
          res_valid         = 1'b1;
          res.data_byte     = b ^ kbyte;
          res.last_of_frame = last;
        end
        default: begin
          fin_nxt   = b[7];
          op_nxt    = b[3:0];
          phase_nxt = wsd_pkg::PH_HDR1;
        end
      endcase

      // length known: key next when masked, else payload
      if (len_done) begin
        cnt_nxt = '0;
        if (mask_nxt) begin
          key_nxt   = '0;
          phase_nxt = wsd_pkg::PH_KEY;
        end else begin
          pay_start = 1'b1;
        end
      end

      if (pay_start) begin
        pos_nxt = '0;
        if (left_nxt == '0) begin
          phase_nxt          = wsd_pkg::PH_HDR0;
          res_valid          = 1'b1;
          res.data_byte      = '0;
          res.was_masked     = mask_nxt;
          res.last_of_frame  = 1'b1;
          res.empty_frame    = 1'b1;
        end else begin
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
    end
  end

endmodule

@@ design/wsd_out_reg.sv @@
// result register driving the output channel
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output wsd_pkg::result_t out_res,
  output logic             slot_free
);

  logic             valid_r, valid_nxt;
  wsd_pkg::result_t res_r;

  assign slot_free = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt = valid_r & out_stall;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
